// ===== rtl/jdrq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the joystick direction repeat qualifier
// no dependencies

package jdrq_pkg;

  localparam int AxisW = 12;
  localparam int TimeW = 32;
  localparam int MsW   = 16;
  localparam int DirW  = 3;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef logic [AxisW-1:0] axis_t;
  typedef logic [TimeW-1:0] stamp_t;
  typedef logic [MsW-1:0]   ms_t;

  typedef enum logic [DirW-1:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4,
    DIR_PRESS = 3'd5
  } dir_t;

  typedef enum logic [2:0] {
    REG_AXIS_CENTER     = 3'd0,
    REG_AXIS_THRESHOLD  = 3'd1,
    REG_DEBOUNCE_MS     = 3'd2,
    REG_REPEAT_FIRST_MS = 3'd3,
    REG_REPEAT_NEXT_MS  = 3'd4
  } reg_idx_t;

  localparam axis_t RstAxisCenter    = 12'd2048;
  localparam axis_t RstAxisThreshold = 12'd1800;
  localparam ms_t   RstDebounceMs    = 16'd50;
  localparam ms_t   RstRepeatFirstMs = 16'd300;
  localparam ms_t   RstRepeatNextMs  = 16'd150;

endpackage

// ===== rtl/joystick_direction_repeat_qualifier.sv =====
`timescale 1ns / 1ps
// joystick direction and select button qualifier with auto-repeat
// depends on jdrq_pkg
//
// usage:
//   input channel: in_valid/in_ready carry one sample beat (horiz_sample,
//   vert_sample, select_level, now_ms). every accepted beat gives exactly
//   one result beat on the output channel (direction, out_valid/out_ready).
//   each result is registered in the output register, or in the skid register
//   while the output holds a result not yet taken. throughput: one beat per
//   cycle while in_ready is high; the whole decision is one pass of compares
//   and a 32-bit time difference between the input handshake and the output register.
//   stall: a two-entry output (output register plus skid register) lets a
//   beat be taken while a result waits; in_ready drops only when both hold
//   results, and rises again the cycle after the receiver takes one.
//   reset: rst (synchronous) empties the output, returns the registers to
//   their defaults and clears the button and repeat state.
//   configuration: apb port, register i at byte address 4*i, pready always
//   high; write only while idle.

module joystick_direction_repeat_qualifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [jdrq_pkg::AxisW-1:0]  horiz_sample,
  input  logic [jdrq_pkg::AxisW-1:0]  vert_sample,
  input  logic                        select_level,
  input  logic [jdrq_pkg::TimeW-1:0]  now_ms,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic [jdrq_pkg::DirW-1:0]   direction,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jdrq_pkg::AddrW-1:0]  paddr,
  input  logic [jdrq_pkg::DataW-1:0]  pwdata,
  output logic [jdrq_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  jdrq_pkg::axis_t  axis_center;
  jdrq_pkg::axis_t  axis_threshold;
  jdrq_pkg::ms_t    debounce_ms;
  jdrq_pkg::ms_t    repeat_first_ms;
  jdrq_pkg::ms_t    repeat_next_ms;

  logic             raw_button_prev, raw_button_prev_next;
  logic             stable_button, stable_button_next;
  jdrq_pkg::stamp_t button_change_time, button_change_time_next;
  jdrq_pkg::dir_t   held_direction, held_direction_next;
  jdrq_pkg::stamp_t last_emit_time, last_emit_time_next;
  logic             awaiting_first_repeat, awaiting_first_repeat_next;

  jdrq_pkg::dir_t   out_dir;
  jdrq_pkg::dir_t   skid_dir;
  logic             skid_valid;

  jdrq_pkg::dir_t   pick;
  jdrq_pkg::dir_t   result;
  jdrq_pkg::stamp_t btn_elapsed;
  jdrq_pkg::stamp_t emit_elapsed;
  jdrq_pkg::ms_t    repeat_limit;
  logic [jdrq_pkg::AxisW:0] bound_hi;
  logic [jdrq_pkg::AxisW:0] vert_lo;
  logic [jdrq_pkg::AxisW:0] horiz_lo;
  logic [jdrq_pkg::AxisW:0] center_ext;
  logic             accept;
  logic             cfg_write;
  jdrq_pkg::reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = jdrq_pkg::reg_idx_t'(paddr[4:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_center     <= jdrq_pkg::RstAxisCenter;
      axis_threshold  <= jdrq_pkg::RstAxisThreshold;
      debounce_ms     <= jdrq_pkg::RstDebounceMs;
      repeat_first_ms <= jdrq_pkg::RstRepeatFirstMs;
      repeat_next_ms  <= jdrq_pkg::RstRepeatNextMs;
    end else if (cfg_write) begin
      case (cfg_idx)
        jdrq_pkg::REG_AXIS_CENTER:     axis_center     <= pwdata[jdrq_pkg::AxisW-1:0];
        jdrq_pkg::REG_AXIS_THRESHOLD:  axis_threshold  <= pwdata[jdrq_pkg::AxisW-1:0];
        jdrq_pkg::REG_DEBOUNCE_MS:     debounce_ms     <= pwdata[jdrq_pkg::MsW-1:0];
        jdrq_pkg::REG_REPEAT_FIRST_MS: repeat_first_ms <= pwdata[jdrq_pkg::MsW-1:0];
        jdrq_pkg::REG_REPEAT_NEXT_MS:  repeat_next_ms  <= pwdata[jdrq_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      jdrq_pkg::REG_AXIS_CENTER:
        prdata = {{(jdrq_pkg::DataW-jdrq_pkg::AxisW){1'b0}}, axis_center};
      jdrq_pkg::REG_AXIS_THRESHOLD:
        prdata = {{(jdrq_pkg::DataW-jdrq_pkg::AxisW){1'b0}}, axis_threshold};
      jdrq_pkg::REG_DEBOUNCE_MS:
        prdata = {{(jdrq_pkg::DataW-jdrq_pkg::MsW){1'b0}}, debounce_ms};
      jdrq_pkg::REG_REPEAT_FIRST_MS:
        prdata = {{(jdrq_pkg::DataW-jdrq_pkg::MsW){1'b0}}, repeat_first_ms};
      jdrq_pkg::REG_REPEAT_NEXT_MS:
        prdata = {{(jdrq_pkg::DataW-jdrq_pkg::MsW){1'b0}}, repeat_next_ms};
      default: prdata = '0;
    endcase
  end

  // direction pick; lower bound tested as sample + threshold < center
  always_comb begin
    center_ext = {1'b0, axis_center};
    bound_hi   = center_ext + {1'b0, axis_threshold};
    vert_lo    = {1'b0, vert_sample} + {1'b0, axis_threshold};
    horiz_lo   = {1'b0, horiz_sample} + {1'b0, axis_threshold};
    if ({1'b0, vert_sample} > bound_hi) begin
      pick = jdrq_pkg::DIR_UP;
    end else if (vert_lo < center_ext) begin
      pick = jdrq_pkg::DIR_DOWN;
    end else if ({1'b0, horiz_sample} > bound_hi) begin
      pick = jdrq_pkg::DIR_LEFT;
    end else if (horiz_lo < center_ext) begin
      pick = jdrq_pkg::DIR_RIGHT;
    end else begin
      pick = jdrq_pkg::DIR_NONE;
    end
  end

  // button debounce and repeat state
  always_comb begin
    raw_button_prev_next       = select_level;
    stable_button_next         = stable_button;
    button_change_time_next    = button_change_time;
    held_direction_next        = held_direction;
    last_emit_time_next        = last_emit_time;
    awaiting_first_repeat_next = awaiting_first_repeat;
    result                     = jdrq_pkg::DIR_NONE;

    if (select_level != raw_button_prev) begin
      button_change_time_next = now_ms;
      btn_elapsed             = '0;
    end else begin
      btn_elapsed = now_ms - button_change_time;
    end
    emit_elapsed = now_ms - last_emit_time;
    repeat_limit = awaiting_first_repeat ? repeat_first_ms : repeat_next_ms;

    if (btn_elapsed > {{(jdrq_pkg::TimeW-jdrq_pkg::MsW){1'b0}}, debounce_ms} &&
        select_level != stable_button) begin
      stable_button_next = select_level;
    end

    if (stable_button_next != stable_button && !select_level) begin
      result = jdrq_pkg::DIR_PRESS;
    end else if (pick == jdrq_pkg::DIR_NONE) begin
      held_direction_next        = jdrq_pkg::DIR_NONE;
      awaiting_first_repeat_next = 1'b0;
    end else if (pick != held_direction) begin
      held_direction_next        = pick;
      awaiting_first_repeat_next = 1'b1;
      last_emit_time_next        = now_ms;
      result                     = pick;
    end else if (emit_elapsed > {{(jdrq_pkg::TimeW-jdrq_pkg::MsW){1'b0}}, repeat_limit}) begin
      awaiting_first_repeat_next = 1'b0;
      last_emit_time_next        = now_ms;
      result                     = pick;
    end
  end

  assign accept   = in_valid & in_ready;
  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_button_prev       <= 1'b1;
      stable_button         <= 1'b1;
      button_change_time    <= '0;
      held_direction        <= jdrq_pkg::DIR_NONE;
      last_emit_time        <= '0;
      awaiting_first_repeat <= 1'b0;
    end else if (accept) begin
      raw_button_prev       <= raw_button_prev_next;
      stable_button         <= stable_button_next;
      button_change_time    <= button_change_time_next;
      held_direction        <= held_direction_next;
      last_emit_time        <= last_emit_time_next;
      awaiting_first_repeat <= awaiting_first_repeat_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_dir <= skid_valid ? skid_dir : result;
    end
    if (accept) begin
      skid_dir <= result;
    end
  end

  assign direction = out_dir;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for joystick_direction_repeat_qualifier: directed and random samples
// depends on jdrq_pkg and the rtl top; predicts each direction beat and checks it in order

module tb_top;
  import jdrq_pkg::*;

  typedef struct packed {
    axis_t  horiz;
    axis_t  vert;
    logic   sel;
    stamp_t stamp;
  } sample_t;

  localparam int ReadyAlways  = 0;
  localparam int ReadyRandom  = 1;
  localparam int ReadyPattern = 2;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  axis_t        horiz_sample = '0;
  axis_t        vert_sample = '0;
  logic         select_level = 1'b1;
  stamp_t       now_ms = '0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [DirW-1:0] direction;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic         pready;

  joystick_direction_repeat_qualifier dut (
    .clk(clk), .rst(rst),
    .horiz_sample(horiz_sample), .vert_sample(vert_sample),
    .select_level(select_level), .now_ms(now_ms),
    .in_valid(in_valid), .in_ready(in_ready),
    .direction(direction), .out_valid(out_valid), .out_ready(out_ready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register shadow
  axis_t  cfg_center = RstAxisCenter;
  axis_t  cfg_thresh = RstAxisThreshold;
  ms_t    cfg_debounce = RstDebounceMs;
  ms_t    cfg_first = RstRepeatFirstMs;
  ms_t    cfg_next = RstRepeatNextMs;

  // predicted qualifier state
  logic   pin_prev = 1'b1;
  logic   pin_stable = 1'b1;
  stamp_t pin_edge_ms = '0;
  dir_t   held_dir = DIR_NONE;
  stamp_t emit_ms = '0;
  logic   first_pending = 1'b0;

  sample_t sample_fifo[$];
  dir_t    pending_dirs[$];
  sample_t drv_sample;
  stamp_t  sim_ms = '0;

  int   fail_count = 0;
  int   n_accepted = 0;
  int   n_settings = 1;
  int   dir_hits[6];
  bit   idle_on = 1'b0;
  int   ready_mode = ReadyAlways;
  logic [7:0] stall_pat = 8'hff;
  int   pat_pos = 0;
  int   gap_left = 0;
  int   burst_left = 0;

  initial forever #10 clk = ~clk;

  function automatic dir_t qualify_sample(sample_t s);
    int     hi;
    int     lo;
    dir_t   stick;
    dir_t   res;
    stamp_t dt;
    hi = int'(cfg_center) + int'(cfg_thresh);
    lo = int'(cfg_center) - int'(cfg_thresh);
    if (int'(s.vert) > hi) stick = DIR_UP;
    else if (int'(s.vert) < lo) stick = DIR_DOWN;
    else if (int'(s.horiz) > hi) stick = DIR_LEFT;
    else if (int'(s.horiz) < lo) stick = DIR_RIGHT;
    else stick = DIR_NONE;
    res = DIR_NONE;
    if (s.sel != pin_prev) pin_edge_ms = s.stamp;
    dt = s.stamp - pin_edge_ms;
    if (dt > stamp_t'(cfg_debounce) && s.sel != pin_stable) begin
      pin_stable = s.sel;
      if (!pin_stable) begin
        pin_prev = s.sel;
        return DIR_PRESS;
      end
    end
    pin_prev = s.sel;
    if (stick == DIR_NONE) begin
      held_dir = DIR_NONE;
      first_pending = 1'b0;
    end else if (stick != held_dir) begin
      held_dir = stick;
      first_pending = 1'b1;
      emit_ms = s.stamp;
      res = stick;
    end else if (first_pending) begin
      if (s.stamp - emit_ms > stamp_t'(cfg_first)) begin
        first_pending = 1'b0;
        emit_ms = s.stamp;
        res = stick;
      end
    end else if (s.stamp - emit_ms > stamp_t'(cfg_next)) begin
      emit_ms = s.stamp;
      res = stick;
    end
    return res;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_dirs.push_back(qualify_sample(drv_sample));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (idle_on && gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_fifo.size() > 0) begin
          drv_sample = sample_fifo.pop_front();
          horiz_sample <= drv_sample.horiz;
          vert_sample <= drv_sample.vert;
          select_level <= drv_sample.sel;
          now_ms <= drv_sample.stamp;
          in_valid <= 1'b1;
          if (idle_on) begin
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 20);
              gap_left = $urandom_range(1, 6);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_dirs.size() == 0) begin
          $error("direction beat %0d with nothing pending", direction);
          fail_count++;
        end else begin
          dir_t want;
          want = pending_dirs.pop_front();
          if (direction !== want) begin
            $error("direction mismatch: expected %0d, got %0d", want, direction);
            fail_count++;
          end
          if (direction < 6) dir_hits[direction]++;
        end
      end
      case (ready_mode)
        ReadyAlways: out_ready <= 1'b1;
        ReadyRandom: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= stall_pat[pat_pos];
          pat_pos = (pat_pos + 1) % 8;
        end
      endcase
    end
  end

  task automatic push_sample(int h, int v, logic sel, stamp_t t);
    sample_t s;
    s.horiz = axis_t'(h);
    s.vert = axis_t'(v);
    s.sel = sel;
    s.stamp = t;
    sample_fifo.push_back(s);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sample_fifo.size() != 0 || in_valid || pending_dirs.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic apb_write(int idx, logic [DataW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_AXIS_CENTER:     cfg_center = axis_t'(val);
      REG_AXIS_THRESHOLD:  cfg_thresh = axis_t'(val);
      REG_DEBOUNCE_MS:     cfg_debounce = ms_t'(val);
      REG_REPEAT_FIRST_MS: cfg_first = ms_t'(val);
      REG_REPEAT_NEXT_MS:  cfg_next = ms_t'(val);
      default: ;
    endcase
  endtask

  // upper bits beyond each register's width are junk half the time
  task automatic set_config(int c, int t, int d, int f, int n);
    logic [DataW-1:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : '0;
    apb_write(REG_AXIS_CENTER, {junk[31:12], 12'(c)});
    apb_write(REG_AXIS_THRESHOLD, {junk[31:12], 12'(t)});
    apb_write(REG_DEBOUNCE_MS, {junk[31:16], 16'(d)});
    apb_write(REG_REPEAT_FIRST_MS, {junk[31:16], 16'(f)});
    apb_write(REG_REPEAT_NEXT_MS, {junk[31:16], 16'(n)});
    n_settings++;
  endtask

  function automatic int axis_between(int lo, int hi);
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    if (lo > 4095) lo = 4095;
    if (hi < 0) hi = 0;
    if (lo > hi) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // held stick positions with bouncy button segments, some noise and time wraps
  task automatic gen_walk(int n, int step_max);
    int   made;
    int   seg;
    int   kind;
    int   h;
    int   v;
    int   c;
    int   t;
    logic btn;
    logic lvl;
    made = 0;
    c = int'(cfg_center);
    t = int'(cfg_thresh);
    while (made < n) begin
      seg = $urandom_range(1, 25);
      kind = $urandom_range(0, 5);
      btn = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 39) == 0) sim_ms = 32'hffff_ffff - $urandom_range(0, 4 * step_max);
      for (int i = 0; i < seg && made < n; i++) begin
        h = axis_between(c - t / 2, c + t / 2);
        v = axis_between(c - t / 2, c + t / 2);
        case (kind)
          1: v = axis_between(c + t + 1, 4095);
          2: v = axis_between(0, c - t - 1);
          3: h = axis_between(c + t + 1, 4095);
          4: h = axis_between(0, c - t - 1);
          5: begin
            h = $urandom_range(0, 4095);
            v = $urandom_range(0, 4095);
          end
          default: ;
        endcase
        lvl = (i < 3 && $urandom_range(0, 3) == 0) ? ~btn : btn;
        if ($urandom_range(0, 19) == 0) begin
          sim_ms = $urandom;
          push_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
                      1'($urandom_range(0, 1)), sim_ms);
        end else begin
          sim_ms += $urandom_range(0, step_max);
          push_sample(h, v, lvl, sim_ms);
        end
        made++;
      end
    end
  endtask

  task automatic run_phase(int n, int step_max, bit idle, int rmode, bit squeeze);
    idle_on = idle;
    ready_mode = rmode;
    stall_pat = 8'($urandom) | 8'h01;
    if (squeeze) begin
      gen_walk(n / 2, step_max);
      wait_idle();
      gen_walk(n - n / 2, step_max);
    end else begin
      gen_walk(n, step_max);
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part on reset settings
    push_sample(2048, 2048, 1'b1, 0);
    push_sample(2048, 4095, 1'b1, 10);
    push_sample(2048, 4095, 1'b1, 310);
    push_sample(2048, 4095, 1'b1, 311);
    push_sample(2048, 4095, 1'b1, 461);
    push_sample(2048, 4095, 1'b1, 462);
    push_sample(2048, 3848, 1'b1, 470);
    push_sample(2048, 3849, 1'b1, 471);
    push_sample(2048, 248, 1'b1, 472);
    push_sample(2048, 247, 1'b1, 473);
    push_sample(2048, 0, 1'b1, 474);
    push_sample(4095, 2048, 1'b1, 475);
    push_sample(0, 2048, 1'b1, 476);
    push_sample(4095, 4095, 1'b1, 477);
    push_sample(0, 0, 1'b1, 478);
    push_sample(2048, 2048, 1'b0, 1000);
    push_sample(2048, 2048, 1'b0, 1050);
    push_sample(2048, 2048, 1'b0, 1051);
    push_sample(2048, 4095, 1'b0, 1060);
    push_sample(2048, 2048, 1'b1, 1100);
    push_sample(2048, 2048, 1'b0, 1120);
    push_sample(2048, 2048, 1'b1, 1130);
    push_sample(2048, 2048, 1'b1, 1181);
    push_sample(2048, 2048, 1'b0, 32'hffff_ffe0);
    push_sample(2048, 2048, 1'b0, 32'h0000_0020);
    push_sample(2048, 4095, 1'b1, 32'h0000_0030);
    wait_idle();
    sim_ms = 32'd2000;

    run_phase(180, 90, 1'b1, ReadyRandom, 1'b1);
    set_config(0, 0, 0, 0, 0);
    run_phase(180, 5, 1'b0, ReadyAlways, 1'b0);
    set_config(4095, 4095, 65535, 65535, 65535);
    run_phase(180, 20000, 1'b1, ReadyPattern, 1'b0);
    set_config(0, 4095, 10, 20, 5);
    run_phase(180, 15, 1'b1, ReadyRandom, 1'b0);

    // writes past the last register must change nothing
    for (int k = 1; k <= 3; k++) apb_write(int'(REG_REPEAT_NEXT_MS) + k, $urandom);

    for (int p = 0; p < 4; p++) begin
      set_config($urandom_range(0, 4095), $urandom_range(0, 2047), $urandom_range(0, 200),
                 $urandom_range(0, 400), $urandom_range(0, 200));
      run_phase(180, $urandom_range(20, 150), p[0], p % 3, p == 2);
    end

    repeat (10) @(posedge clk);
    $display("%0d samples accepted across %0d register settings", n_accepted, n_settings);
    $display("results none %0d up %0d down %0d left %0d right %0d press %0d",
             dir_hits[0], dir_hits[1], dir_hits[2], dir_hits[3], dir_hits[4], dir_hits[5]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d beats pending", pending_dirs.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
